### src/i2cm_pkg.sv
`timescale 1ns / 1ps
// i2cm_pkg: shared types, codes and sizes of the i2c master transaction engine
// no dependencies; used by i2cm_wbuf, i2cm_seq and i2c_master_transaction_engine

package i2cm_pkg;

  localparam int unsigned MaxLen       = 256;
  localparam int unsigned MaxAddrBytes = 4;
  localparam int unsigned BufAddrW     = $clog2(MaxLen);
  localparam int unsigned LenW         = $clog2(MaxLen + 1);
  localparam int unsigned AddrSelW     = $clog2(MaxAddrBytes);

  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpStart = 2'd1;
  localparam logic [1:0] OpLoad  = 2'd2;

  localparam logic [1:0] TxnRandRead = 2'd0;
  localparam logic [1:0] TxnSeqRead  = 2'd1;
  localparam logic [1:0] TxnWrite    = 2'd2;
  localparam logic [1:0] TxnUnsup    = 2'd3;

  localparam logic [1:0] RoleDevW = 2'd0;
  localparam logic [1:0] RoleMem  = 2'd1;
  localparam logic [1:0] RoleDevR = 2'd2;
  localparam logic [1:0] RoleData = 2'd3;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatNoAck  = 2'd1;
  localparam logic [1:0] StatUnsup  = 2'd2;

  typedef enum logic [7:0] {
    PhIdle    = 8'b0000_0001,
    PhStart   = 8'b0000_0010,
    PhWbit    = 8'b0000_0100,
    PhWack    = 8'b0000_1000,
    PhRestart = 8'b0001_0000,
    PhRbyte   = 8'b0010_0000,
    PhRack    = 8'b0100_0000,
    PhStop    = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic            sda_in;
    logic [1:0]      txn_type;
    logic [7:0]      dev_addr;
    logic [31:0]     mem_addr;
    logic [2:0]      mem_addr_count;
    logic [LenW-1:0] length;
    logic [7:0]      wr_data;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       done_res;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic                wr_en;
    logic [BufAddrW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic [BufAddrW-1:0] rd_addr;
  } buf_req_t;

endpackage

### src/i2cm_wbuf.sv
`timescale 1ns / 1ps
// i2cm_wbuf: write data buffer, one write port and one read port, registered read
// depends on i2cm_pkg

module i2cm_wbuf (
  input  logic                          clk_i,
  input  i2cm_pkg::buf_req_t            req_i,
  output logic [7:0]                    rd_data_o
);

  logic [7:0] mem_q [i2cm_pkg::MaxLen];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_q <= mem_q[req_i.rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/i2cm_seq.sv
`timescale 1ns / 1ps
// i2cm_seq: bus sequencer, advances one delay period per tick and forms the result
// depends on i2cm_pkg; reads write data from i2cm_wbuf in the cycle after addressing

module i2cm_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_i,
  input  i2cm_pkg::item_t      item_data_i,
  input  logic [7:0]           buf_data_i,
  output i2cm_pkg::buf_req_t   buf_req_o,
  output i2cm_pkg::result_t    result_o
);

  localparam int unsigned LenW = i2cm_pkg::LenW;

  i2cm_pkg::phase_e phase_q, phase_d;
  logic [2:0]       sub_q, sub_d;
  logic [2:0]       bit_q, bit_d;
  logic [LenW-1:0]  bc_q, bc_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [7:0]       shift_q, shift_d;
  logic [31:0]      addr_shift_q, addr_shift_d;
  logic [2:0]       addr_left_q, addr_left_d;
  logic [1:0]       kind_q, kind_d;
  logic [1:0]       role_q, role_d;
  logic [7:0]       addr_byte_q, addr_byte_d;
  logic [LenW-1:0]  fill_q, fill_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic [1:0]       res_q, res_d;

  logic             busy;
  logic             tgt_en;
  i2cm_pkg::phase_e tgt_ph;
  logic [7:0]       wb_byte;
  logic [1:0]       wb_role;
  logic [2:0]       al;
  logic [2:0]       al_m1;
  logic [LenW-1:0]  bc_inc;
  logic             ev_valid;
  logic             ev_done;
  logic             buf_we;

  assign busy = (phase_q != i2cm_pkg::PhIdle);

  always_comb begin
    phase_d      = phase_q;
    sub_d        = sub_q;
    bit_d        = bit_q;
    bc_d         = bc_q;
    len_d        = len_q;
    shift_d      = shift_q;
    addr_shift_d = addr_shift_q;
    addr_left_d  = addr_left_q;
    kind_d       = kind_q;
    role_d       = role_q;
    addr_byte_d  = addr_byte_q;
    fill_d       = fill_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    res_d        = res_q;
    tgt_en       = 1'b0;
    tgt_ph       = i2cm_pkg::PhStop;
    wb_byte      = buf_data_i;
    wb_role      = i2cm_pkg::RoleData;
    al           = addr_left_q;
    al_m1        = addr_left_q - 3'd1;
    bc_inc       = bc_q + LenW'(1);
    ev_valid     = 1'b0;
    ev_done      = 1'b0;
    buf_we       = 1'b0;

    if (item_i) begin
      case (item_data_i.opcode)
        i2cm_pkg::OpTick: begin
          if (busy) begin
            case (phase_q)
              i2cm_pkg::PhStart: begin
                if (sub_q == 3'd0) begin
                  tgt_en = 1'b1;
                  tgt_ph = i2cm_pkg::PhStart;
                end else begin
                  scl_d   = 1'b0;
                  wb_byte = addr_byte_q;
                  wb_role = addr_byte_q[0] ? i2cm_pkg::RoleDevR : i2cm_pkg::RoleDevW;
                  tgt_en  = 1'b1;
                  tgt_ph  = i2cm_pkg::PhWbit;
                end
              end
              i2cm_pkg::PhWbit: begin
                if (sub_q == 3'd0) begin
                  scl_d = 1'b0;
                  sda_d = shift_q[bit_q];
                  sub_d = 3'd1;
                end else if (sub_q == 3'd1) begin
                  scl_d = 1'b1;
                  sub_d = 3'd2;
                end else if (bit_q == 3'd0) begin
                  scl_d  = 1'b0;
                  tgt_en = 1'b1;
                  tgt_ph = i2cm_pkg::PhWack;
                end else begin
                  bit_d = bit_q - 3'd1;
                  scl_d = 1'b0;
                  sda_d = shift_q[bit_q - 3'd1];
                  sub_d = 3'd1;
                end
              end
              i2cm_pkg::PhWack: begin
                if (sub_q == 3'd0) begin
                  sda_d = 1'b1;
                  sub_d = 3'd1;
                end else if (sub_q == 3'd1) begin
                  scl_d = 1'b1;
                  sub_d = 3'd2;
                end else begin
                  scl_d  = 1'b0;
                  tgt_en = 1'b1;
                  if (item_data_i.sda_in) begin
                    res_d  = i2cm_pkg::StatNoAck;
                    tgt_ph = i2cm_pkg::PhStop;
                  end else begin
                    case (role_q)
                      i2cm_pkg::RoleDevW, i2cm_pkg::RoleMem: begin
                        al          = (role_q == i2cm_pkg::RoleMem) ?
                                      addr_left_q - 3'd1 : addr_left_q;
                        al_m1       = al - 3'd1;
                        addr_left_d = al;
                        if (al != 3'd0) begin
                          wb_byte = addr_shift_q[{al_m1[i2cm_pkg::AddrSelW-1:0], 3'b000} +: 8];
                          wb_role = i2cm_pkg::RoleMem;
                          tgt_ph  = i2cm_pkg::PhWbit;
                        end else if (kind_q == i2cm_pkg::TxnRandRead) begin
                          tgt_ph = i2cm_pkg::PhRestart;
                        end else if (bc_q < len_q) begin
                          tgt_ph = i2cm_pkg::PhWbit;
                        end else begin
                          tgt_ph = i2cm_pkg::PhStop;
                        end
                      end
                      i2cm_pkg::RoleDevR: begin
                        tgt_ph = (len_q != '0) ? i2cm_pkg::PhRbyte : i2cm_pkg::PhStop;
                      end
                      default: begin
                        bc_d   = bc_inc;
                        tgt_ph = (bc_inc < len_q) ? i2cm_pkg::PhWbit : i2cm_pkg::PhStop;
                      end
                    endcase
                  end
                end
              end
              i2cm_pkg::PhRestart: begin
                if (sub_q == 3'd0) begin
                  scl_d = 1'b1;
                  sub_d = 3'd1;
                end else begin
                  addr_byte_d = addr_byte_q | 8'h01;
                  tgt_en      = 1'b1;
                  tgt_ph      = i2cm_pkg::PhStart;
                end
              end
              i2cm_pkg::PhRbyte: begin
                if (sub_q == 3'd0) begin
                  tgt_en = 1'b1;
                  tgt_ph = i2cm_pkg::PhRbyte;
                end else if (sub_q == 3'd1) begin
                  scl_d = 1'b1;
                  sub_d = 3'd2;
                end else if (sub_q == 3'd2) begin
                  shift_d  = {shift_q[6:0], item_data_i.sda_in};
                  scl_d    = 1'b0;
                  ev_valid = (bit_q == 3'd7);
                  sub_d    = 3'd3;
                end else if (bit_q == 3'd7) begin
                  tgt_en = 1'b1;
                  tgt_ph = i2cm_pkg::PhRack;
                end else begin
                  bit_d = bit_q + 3'd1;
                  scl_d = 1'b1;
                  sub_d = 3'd2;
                end
              end
              i2cm_pkg::PhRack: begin
                if (sub_q == 3'd0) begin
                  tgt_en = 1'b1;
                  tgt_ph = i2cm_pkg::PhRack;
                end else if (sub_q == 3'd1) begin
                  scl_d = 1'b1;
                  sub_d = 3'd2;
                end else begin
                  scl_d  = 1'b0;
                  tgt_en = 1'b1;
                  tgt_ph = (bc_q < len_q) ? i2cm_pkg::PhRbyte : i2cm_pkg::PhStop;
                end
              end
              i2cm_pkg::PhStop: begin
                case (sub_q)
                  3'd0: begin
                    scl_d = 1'b0;
                    sub_d = 3'd1;
                  end
                  3'd1: begin
                    sda_d = 1'b0;
                    sub_d = 3'd2;
                  end
                  3'd2: begin
                    scl_d = 1'b1;
                    sub_d = 3'd3;
                  end
                  3'd3: begin
                    sda_d = 1'b1;
                    sub_d = 3'd4;
                  end
                  default: begin
                    ev_done = 1'b1;
                    fill_d  = '0;
                    phase_d = i2cm_pkg::PhIdle;
                    sub_d   = 3'd0;
                  end
                endcase
              end
              default: begin
                phase_d = i2cm_pkg::PhIdle;
                sub_d   = 3'd0;
              end
            endcase
          end
        end
        i2cm_pkg::OpStart: begin
          if (!busy) begin
            if (item_data_i.txn_type == i2cm_pkg::TxnUnsup) begin
              res_d   = i2cm_pkg::StatUnsup;
              ev_done = 1'b1;
              fill_d  = '0;
            end else begin
              kind_d       = item_data_i.txn_type;
              addr_shift_d = item_data_i.mem_addr;
              addr_left_d  = (item_data_i.mem_addr_count > 3'(i2cm_pkg::MaxAddrBytes)) ?
                             3'(i2cm_pkg::MaxAddrBytes) : item_data_i.mem_addr_count;
              len_d        = (item_data_i.length > LenW'(i2cm_pkg::MaxLen)) ?
                             LenW'(i2cm_pkg::MaxLen) : item_data_i.length;
              bc_d         = '0;
              res_d        = i2cm_pkg::StatOk;
              addr_byte_d  = (item_data_i.txn_type == i2cm_pkg::TxnSeqRead) ?
                             (item_data_i.dev_addr | 8'h01) : (item_data_i.dev_addr & 8'hFE);
              tgt_en       = 1'b1;
              tgt_ph       = i2cm_pkg::PhStart;
            end
          end
        end
        i2cm_pkg::OpLoad: begin
          if (!busy && (fill_q < LenW'(i2cm_pkg::MaxLen))) begin
            buf_we = 1'b1;
            fill_d = fill_q + LenW'(1);
          end
        end
        default: ;
      endcase

      // entry step of the phase just reached
      if (tgt_en) begin
        case (tgt_ph)
          i2cm_pkg::PhStart: begin
            if (!item_data_i.sda_in) begin
              res_d   = i2cm_pkg::StatNoAck;
              scl_d   = 1'b0;
              phase_d = i2cm_pkg::PhStop;
              sub_d   = 3'd1;
            end else begin
              sda_d   = 1'b0;
              phase_d = i2cm_pkg::PhStart;
              sub_d   = 3'd1;
            end
          end
          i2cm_pkg::PhWbit: begin
            shift_d = wb_byte;
            bit_d   = 3'd7;
            role_d  = wb_role;
            scl_d   = 1'b0;
            sda_d   = wb_byte[7];
            phase_d = i2cm_pkg::PhWbit;
            sub_d   = 3'd1;
          end
          i2cm_pkg::PhWack: begin
            sda_d   = 1'b1;
            phase_d = i2cm_pkg::PhWack;
            sub_d   = 3'd1;
          end
          i2cm_pkg::PhRestart: begin
            scl_d   = 1'b1;
            phase_d = i2cm_pkg::PhRestart;
            sub_d   = 3'd1;
          end
          i2cm_pkg::PhRbyte: begin
            sda_d   = 1'b1;
            bit_d   = 3'd0;
            shift_d = 8'h00;
            phase_d = i2cm_pkg::PhRbyte;
            sub_d   = 3'd1;
          end
          i2cm_pkg::PhRack: begin
            bc_d    = bc_inc;
            sda_d   = (bc_inc < len_q) ? 1'b0 : 1'b1;
            phase_d = i2cm_pkg::PhRack;
            sub_d   = 3'd1;
          end
          default: begin
            scl_d   = 1'b0;
            phase_d = i2cm_pkg::PhStop;
            sub_d   = 3'd1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= i2cm_pkg::PhIdle;
      sub_q        <= '0;
      bit_q        <= '0;
      bc_q         <= '0;
      len_q        <= '0;
      shift_q      <= '0;
      addr_shift_q <= '0;
      addr_left_q  <= '0;
      kind_q       <= '0;
      role_q       <= i2cm_pkg::RoleDevW;
      addr_byte_q  <= '0;
      fill_q       <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      res_q        <= i2cm_pkg::StatOk;
    end else begin
      phase_q      <= phase_d;
      sub_q        <= sub_d;
      bit_q        <= bit_d;
      bc_q         <= bc_d;
      len_q        <= len_d;
      shift_q      <= shift_d;
      addr_shift_q <= addr_shift_d;
      addr_left_q  <= addr_left_d;
      kind_q       <= kind_d;
      role_q       <= role_d;
      addr_byte_q  <= addr_byte_d;
      fill_q       <= fill_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      res_q        <= res_d;
    end
  end

  // prefetch the next data byte: the one after the current while sending data
  always_comb begin
    buf_req_o.wr_en   = buf_we;
    buf_req_o.wr_addr = fill_q[i2cm_pkg::BufAddrW-1:0];
    buf_req_o.wr_data = item_data_i.wr_data;
    buf_req_o.rd_addr = (role_q == i2cm_pkg::RoleData) ?
                        bc_inc[i2cm_pkg::BufAddrW-1:0] : bc_q[i2cm_pkg::BufAddrW-1:0];
  end

  always_comb begin
    if (item_data_i.opcode == i2cm_pkg::OpTick) begin
      result_o.scl_out = scl_q;
      result_o.sda_out = sda_q;
    end else begin
      result_o.scl_out = scl_d;
      result_o.sda_out = sda_d;
    end
    result_o.busy_res = (phase_d != i2cm_pkg::PhIdle);
    result_o.rd_valid = ev_valid;
    result_o.rd_data  = ev_valid ? shift_d : 8'h00;
    result_o.done_res = ev_done;
    result_o.status   = ev_done ? res_d : i2cm_pkg::StatOk;
  end

endmodule

### src/i2c_master_transaction_engine.sv
`timescale 1ns / 1ps
// i2c_master_transaction_engine: top level, stream ports and result register
// depends on i2cm_pkg, i2cm_wbuf and i2cm_seq

// Every input transfer (tick, start or write-byte load) is taken and yields
// exactly one result transfer, registered and offered in the cycle after, so items can
// follow back to back; a held result stalls input only while the output
// register is full and not being taken. A tick stands for one bus delay period;
// the result carries the SCL/SDA levels driven during it, any read byte that
// completed and, on the stop, the status. Write bytes are loaded into a
// 256-entry buffer while idle and read back through a registered
// port that is addressed ahead of use, so write data never costs extra cycles.
// The buffer is emptied when each transaction ends.

module i2c_master_transaction_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sda_in, txn_type, dev_addr, mem_addr, mem_addr_count, length, wr_data, pad
  input  logic [63:0] s_axis_tdata,
  // opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_out, sda_out, busy_res, rd_data, status, pad
  output logic [15:0] m_axis_tdata,
  // rd_valid
  output logic        m_axis_tuser,
  // done_res
  output logic        m_axis_tlast
);

  i2cm_pkg::item_t    item;
  i2cm_pkg::result_t  result;
  i2cm_pkg::buf_req_t buf_req;
  logic [7:0]         buf_data;
  logic               accept;

  logic               out_valid_q;
  i2cm_pkg::result_t  out_q;

  assign item.opcode         = s_axis_tuser;
  assign item.sda_in         = s_axis_tdata[0];
  assign item.txn_type       = s_axis_tdata[2:1];
  assign item.dev_addr       = s_axis_tdata[10:3];
  assign item.mem_addr       = s_axis_tdata[42:11];
  assign item.mem_addr_count = s_axis_tdata[45:43];
  assign item.length         = s_axis_tdata[54:46];
  assign item.wr_data        = s_axis_tdata[62:55];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  i2cm_wbuf u_wbuf (
    .clk_i     (clk_i),
    .req_i     (buf_req),
    .rd_data_o (buf_data)
  );

  i2cm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (accept),
    .item_data_i (item),
    .buf_data_i  (buf_data),
    .buf_req_o   (buf_req),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.status, out_q.rd_data,
                          out_q.busy_res, out_q.sda_out, out_q.scl_out};
  assign m_axis_tuser  = out_q.rd_valid;
  assign m_axis_tlast  = out_q.done_res;

endmodule

### tb/i2cm_bus_checker.sv
`timescale 1ns / 1ps
// i2cm_bus_checker: predicts the result transfer of every accepted input item
// of the i2c master transaction engine and compares it with what the engine returns
// depends on i2cm_pkg; instantiated beside the engine by i2c_master_transaction_engine_tb

module i2cm_bus_checker
  import i2cm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  input  logic        m_tuser_i,
  input  logic        m_tlast_i,
  output logic        txn_active_o,
  output logic        ack_slot_o,
  output logic        restart_slot_o,
  output logic [8:0]  fill_o,
  output int          pending_o,
  output int          fail_count_o
);

  phase_e      phase;
  logic [2:0]  sub_step;
  logic [2:0]  bit_count;
  logic [2:0]  addr_left;
  logic [1:0]  byte_role;
  logic [1:0]  txn_kind;
  logic [1:0]  result_code;
  logic [8:0]  byte_count;
  logic [8:0]  txn_len;
  logic [8:0]  write_fill;
  logic [7:0]  shift_byte;
  logic [7:0]  addr_byte;
  logic [31:0] addr_shift;
  logic        scl;
  logic        sda;
  logic [7:0]  wbuf [MaxLen];
  logic        ev_valid;
  logic        ev_done;
  logic [7:0]  ev_data;
  result_t     bus_results_q [$];
  int          mismatches;
  int          pending;

  assign txn_active_o   = (phase != PhIdle);
  assign ack_slot_o     = (phase == PhWack) && (sub_step == 3'd2);
  assign restart_slot_o = (phase == PhRestart) && (sub_step == 3'd1);
  assign fill_o         = write_fill;
  assign pending_o      = pending;
  assign fail_count_o   = mismatches;

  function automatic void go_to(input phase_e p);
    phase    = p;
    sub_step = '0;
  endfunction

  function automatic void begin_write(input logic [7:0] b, input logic [1:0] role);
    shift_byte = b;
    bit_count  = 3'd7;
    byte_role  = role;
    go_to(PhWbit);
  endfunction

  // runs the bus sequence up to the next delay period, smp is the sda sample
  function automatic void advance_bus(input logic smp);
    forever begin
      case (phase)
        PhStart: begin
          if (sub_step == 3'd0) begin
            if (!smp) begin
              result_code = StatNoAck;
              go_to(PhStop);
            end else begin
              sda      = 1'b0;
              sub_step = 3'd1;
              return;
            end
          end else begin
            scl = 1'b0;
            begin_write(addr_byte, addr_byte[0] ? RoleDevR : RoleDevW);
          end
        end
        PhWbit: begin
          if (sub_step == 3'd0) begin
            scl      = 1'b0;
            sda      = shift_byte[bit_count];
            sub_step = 3'd1;
            return;
          end else if (sub_step == 3'd1) begin
            scl      = 1'b1;
            sub_step = 3'd2;
            return;
          end else if (bit_count == 3'd0) begin
            scl = 1'b0;
            go_to(PhWack);
          end else begin
            bit_count--;
            sub_step = 3'd0;
          end
        end
        PhWack: begin
          if (sub_step == 3'd0) begin
            sda      = 1'b1;
            sub_step = 3'd1;
            return;
          end else if (sub_step == 3'd1) begin
            scl      = 1'b1;
            sub_step = 3'd2;
            return;
          end
          scl = 1'b0;
          if (smp) begin
            result_code = StatNoAck;
            go_to(PhStop);
          end else begin
            case (byte_role)
              RoleDevW, RoleMem: begin
                if (byte_role == RoleMem) addr_left--;
                if (addr_left != 3'd0) begin
                  begin_write(8'(addr_shift >> {addr_left - 3'd1, 3'b000}), RoleMem);
                end else if (txn_kind == TxnRandRead) begin
                  go_to(PhRestart);
                end else if (byte_count < txn_len) begin
                  begin_write(wbuf[byte_count[BufAddrW-1:0]], RoleData);
                end else begin
                  go_to(PhStop);
                end
              end
              RoleDevR: begin
                go_to((txn_len != '0) ? PhRbyte : PhStop);
              end
              default: begin
                byte_count++;
                if (byte_count < txn_len) begin
                  begin_write(wbuf[byte_count[BufAddrW-1:0]], RoleData);
                end else begin
                  go_to(PhStop);
                end
              end
            endcase
          end
        end
        PhRestart: begin
          if (sub_step == 3'd0) begin
            scl      = 1'b1;
            sub_step = 3'd1;
            return;
          end
          addr_byte = addr_byte | 8'h01;
          go_to(PhStart);
        end
        PhRbyte: begin
          if (sub_step == 3'd0) begin
            sda        = 1'b1;
            bit_count  = 3'd0;
            shift_byte = '0;
            sub_step   = 3'd1;
            return;
          end else if (sub_step == 3'd1) begin
            scl      = 1'b1;
            sub_step = 3'd2;
            return;
          end else if (sub_step == 3'd2) begin
            shift_byte = {shift_byte[6:0], smp};
            scl        = 1'b0;
            if (bit_count == 3'd7) begin
              ev_valid = 1'b1;
              ev_data  = shift_byte;
            end
            sub_step = 3'd3;
            return;
          end else if (bit_count == 3'd7) begin
            go_to(PhRack);
          end else begin
            bit_count++;
            sub_step = 3'd1;
          end
        end
        PhRack: begin
          if (sub_step == 3'd0) begin
            byte_count++;
            sda      = !(byte_count < txn_len);
            sub_step = 3'd1;
            return;
          end else if (sub_step == 3'd1) begin
            scl      = 1'b1;
            sub_step = 3'd2;
            return;
          end
          scl = 1'b0;
          go_to((byte_count < txn_len) ? PhRbyte : PhStop);
        end
        PhStop: begin
          case (sub_step)
            3'd0: scl = 1'b0;
            3'd1: sda = 1'b0;
            3'd2: scl = 1'b1;
            3'd3: sda = 1'b1;
            default: begin
              ev_done    = 1'b1;
              write_fill = '0;
              go_to(PhIdle);
              return;
            end
          endcase
          sub_step++;
          return;
        end
        default: begin
          go_to(PhIdle);
          return;
        end
      endcase
    end
  endfunction

  function automatic result_t step_engine(input item_t it);
    logic    was_busy;
    logic    lv_scl;
    logic    lv_sda;
    result_t r;
    was_busy = (phase != PhIdle);
    lv_scl   = scl;
    lv_sda   = sda;
    ev_valid = 1'b0;
    ev_data  = '0;
    ev_done  = 1'b0;
    case (it.opcode)
      OpTick: begin
        if (was_busy) advance_bus(it.sda_in);
      end
      OpStart: begin
        if (!was_busy) begin
          if (it.txn_type == TxnUnsup) begin
            result_code = StatUnsup;
            ev_done     = 1'b1;
            write_fill  = '0;
          end else begin
            txn_kind   = it.txn_type;
            addr_shift = it.mem_addr;
            addr_left  = (it.mem_addr_count > MaxAddrBytes) ? 3'(MaxAddrBytes)
                                                              : it.mem_addr_count;
            txn_len    = (it.length > MaxLen) ? LenW'(MaxLen) : it.length;
            byte_count = '0;
            result_code = StatOk;
            addr_byte  = (it.txn_type == TxnSeqRead) ? (it.dev_addr | 8'h01)
                                                      : (it.dev_addr & 8'hFE);
            go_to(PhStart);
            advance_bus(it.sda_in);
          end
        end
        lv_scl = scl;
        lv_sda = sda;
      end
      default: begin
        if (it.opcode == OpLoad && !was_busy && write_fill < MaxLen) begin
          wbuf[write_fill[BufAddrW-1:0]] = it.wr_data;
          write_fill++;
        end
      end
    endcase
    r.scl_out  = lv_scl;
    r.sda_out  = lv_sda;
    r.busy_res = (phase != PhIdle);
    r.rd_valid = ev_valid;
    r.rd_data  = ev_valid ? ev_data : '0;
    r.done_res = ev_done;
    r.status   = ev_done ? result_code : StatOk;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   it;
    result_t want;
    if (!rst_ni) begin
      bus_results_q.delete();
      go_to(PhIdle);
      bit_count   = '0;
      addr_left   = '0;
      byte_role   = RoleDevW;
      txn_kind    = TxnRandRead;
      result_code = StatOk;
      byte_count  = '0;
      txn_len     = '0;
      write_fill  = '0;
      shift_byte  = '0;
      addr_byte   = '0;
      addr_shift  = '0;
      scl         = 1'b1;
      sda         = 1'b1;
      ev_valid    = 1'b0;
      ev_done     = 1'b0;
      ev_data     = '0;
      mismatches  = 0;
      pending     = 0;
    end else begin
      // a result always trails its item, so compare before queueing the new one
      if (m_tvalid_i && m_tready_i) begin
        if (bus_results_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatches++;
        end else begin
          want = bus_results_q.pop_front();
          check_field("scl_out", want.scl_out, m_tdata_i[0]);
          check_field("sda_out", want.sda_out, m_tdata_i[1]);
          check_field("busy_res", want.busy_res, m_tdata_i[2]);
          check_field("rd_data", want.rd_data, m_tdata_i[10:3]);
          check_field("status", want.status, m_tdata_i[12:11]);
          check_field("rd_valid", want.rd_valid, m_tuser_i);
          check_field("done_res", want.done_res, m_tlast_i);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        it.opcode         = s_tuser_i;
        it.sda_in         = s_tdata_i[0];
        it.txn_type       = s_tdata_i[2:1];
        it.dev_addr       = s_tdata_i[10:3];
        it.mem_addr       = s_tdata_i[42:11];
        it.mem_addr_count = s_tdata_i[45:43];
        it.length         = s_tdata_i[54:46];
        it.wr_data        = s_tdata_i[62:55];
        bus_results_q.push_back(step_engine(it));
      end
      pending = bus_results_q.size();
    end
  end

endmodule

### tb/i2c_master_transaction_engine_tb.sv
`timescale 1ns / 1ps
// i2c_master_transaction_engine_tb: drives reads, writes, loads and bus ticks with
// random gaps and stalls into the engine and gives the verdict from i2cm_bus_checker
// depends on i2cm_pkg, i2cm_bus_checker and i2c_master_transaction_engine

module i2c_master_transaction_engine_tb;
  import i2cm_pkg::*;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned RandomItems = 950;
  localparam logic [1:0]  OpNone      = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // sda_in, txn_type, dev_addr, mem_addr, mem_addr_count, length, wr_data, pad
  logic [63:0] s_axis_tdata  = '0;
  // opcode
  logic [1:0]  s_axis_tuser  = OpTick;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // scl_out, sda_out, busy_res, rd_data, status, pad
  logic [15:0] m_axis_tdata;
  // rd_valid
  logic        m_axis_tuser;
  // done_res
  logic        m_axis_tlast;

  logic        txn_active;
  logic        ack_slot;
  logic        restart_slot;
  logic [8:0]  fill;
  int          pending;
  int          fail_count;

  int unsigned loaded_max   = 0;
  int unsigned stim_items   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_wait      = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;
  bit          rx_fire      = 1'b0;

  always #5 clk_i = ~clk_i;

  i2c_master_transaction_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  i2cm_bus_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tuser_i      (m_axis_tuser),
    .m_tlast_i      (m_axis_tlast),
    .txn_active_o   (txn_active),
    .ack_slot_o     (ack_slot),
    .restart_slot_o (restart_slot),
    .fill_o         (fill),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  // result side: a fresh random stall, possibly none, after every transfer, with calm stretches
  always @(posedge clk_i) rx_fire <= m_axis_tvalid && m_axis_tready;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_fire) begin
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("** i2c_master_transaction_engine: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t scrambled_item(input logic [1:0] op);
    item_t it;
    it.opcode         = op;
    it.sda_in         = 1'($urandom_range(0, 1));
    it.txn_type       = 2'($urandom_range(0, 3));
    it.dev_addr       = 8'($urandom_range(0, 255));
    it.mem_addr       = $urandom();
    it.mem_addr_count = 3'($urandom_range(0, 7));
    it.length         = 9'($urandom_range(0, 511));
    it.wr_data        = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic push_item(input item_t it);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.opcode;
    s_axis_tdata  <= {1'b0, it.wr_data, it.length, it.mem_addr_count, it.mem_addr,
                      it.dev_addr, it.txn_type, it.sda_in};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    stim_items++;
  endtask

  task automatic load_byte(input logic [7:0] b);
    item_t it;
    it         = scrambled_item(OpLoad);
    it.wr_data = b;
    push_item(it);
    if (fill > loaded_max) loaded_max = fill;
  endtask

  // ack slots and the repeated-start check are steered, data samples are random
  task automatic run_transaction(input logic [1:0] kind, input logic [7:0] dev,
                                 input logic [31:0] addr, input logic [2:0] cnt,
                                 input logic [8:0] len, input logic start_sda,
                                 input int unsigned nack_pct, input int unsigned busy_pct,
                                 input int unsigned noise_pct);
    item_t it;
    it                = scrambled_item(OpStart);
    it.txn_type       = kind;
    it.dev_addr       = dev;
    it.mem_addr       = addr;
    it.mem_addr_count = cnt;
    it.length         = len;
    it.sda_in         = start_sda;
    push_item(it);
    while (txn_active) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0:       it = scrambled_item(OpStart);
          1:       it = scrambled_item(OpLoad);
          default: it = scrambled_item(OpNone);
        endcase
      end else begin
        it = scrambled_item(OpTick);
        if (ack_slot) it.sda_in = ($urandom_range(0, 99) < nack_pct);
        else if (restart_slot) it.sda_in = ($urandom_range(0, 99) >= busy_pct);
      end
      push_item(it);
    end
  endtask

  initial begin
    int unsigned stop_at;
    int unsigned nack_pct;
    int unsigned len_cap;
    logic [1:0]  kind;
    logic [2:0]  cnt;
    logic [8:0]  len;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    push_item(scrambled_item(OpTick));
    push_item(scrambled_item(OpNone));
    load_byte(8'h00);
    load_byte(8'hFF);
    load_byte(8'hA5);
    run_transaction(TxnWrite, 8'hFF, 32'hFFFF_FFFF, 3'd4, 9'd3, 1'b1, 0, 0, 0);
    run_transaction(TxnRandRead, 8'h00, 32'h0000_0000, 3'd2, 9'd2, 1'b1, 0, 0, 0);
    run_transaction(TxnSeqRead, 8'hA0, 32'h1234_5678, 3'd1, 9'd1, 1'b1, 0, 0, 0);
    run_transaction(TxnSeqRead, 8'h5A, 32'h0000_0001, 3'd0, 9'd0, 1'b1, 0, 0, 0);
    run_transaction(TxnWrite, 8'h51, 32'h8000_0000, 3'd0, 9'd0, 1'b1, 0, 0, 0);
    // unsupported type empties the buffer without touching the bus
    load_byte(8'h3C);
    run_transaction(TxnUnsup, 8'hFF, 32'hFFFF_FFFF, 3'd7, 9'd256, 1'b1, 0, 0, 0);
    // bus busy at the opening start and at the repeated start
    run_transaction(TxnWrite, 8'hA0, 32'h0000_00FF, 3'd1, 9'd2, 1'b0, 0, 0, 0);
    run_transaction(TxnRandRead, 8'hA1, 32'h0000_00FF, 3'd1, 9'd1, 1'b1, 0, 100, 0);
    // device never acknowledges, length over the maximum
    run_transaction(TxnSeqRead, 8'hA1, 32'h0, 3'd0, 9'd300, 1'b1, 100, 0, 0);
    // full buffer with extra loads ignored, oversize counts, traffic while busy
    repeat (MaxLen + 4) load_byte(8'($urandom_range(0, 255)));
    run_transaction(TxnWrite, 8'hFE, $urandom(), 3'd7, 9'd511, 1'b1, 25, 0, 10);
    // write longer than the bytes loaded since the last end
    load_byte(8'h81);
    run_transaction(TxnWrite, 8'h50, $urandom(), 3'd1, 9'd6, 1'b1, 0, 0, 0);

    // random part
    stop_at = stim_items + RandomItems;
    while (stim_items < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(scrambled_item($urandom_range(0, 1) ? OpTick : OpNone));
      end
      if ($urandom_range(0, 59) == 0) begin
        repeat (MaxLen + 2) load_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 5)) load_byte(8'($urandom_range(0, 255)));
      end
      kind = ($urandom_range(0, 19) == 0) ? TxnUnsup : 2'($urandom_range(0, 2));
      cnt  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(0, 2));
      case ($urandom_range(0, 19))
        0, 1, 2:       nack_pct = 40;
        3, 4, 5, 6, 7: nack_pct = 5;
        default:       nack_pct = 0;
      endcase
      len_cap = (loaded_max < 6) ? loaded_max : 6;
      len = (kind == TxnWrite) ? 9'($urandom_range(0, len_cap)) : 9'($urandom_range(0, 4));
      if ($urandom_range(0, 19) == 0) begin
        if (kind == TxnWrite) begin
          len      = 9'($urandom_range(0, loaded_max));
          nack_pct = 50;
        end else begin
          len      = 9'($urandom_range(0, 511));
          nack_pct = 100;
        end
      end
      run_transaction(kind, 8'($urandom_range(0, 255)), $urandom(), cnt, len,
                      ($urandom_range(0, 19) != 0), nack_pct, 5, 3);
    end

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** i2c_master_transaction_engine: PASSED **");
    end else begin
      $display("** i2c_master_transaction_engine: FAILED **");
    end
    $finish;
  end

endmodule
